// ----- rtl/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int VAL_W     = 32;
  localparam int PRIO_W    = 16;
  localparam int FILL_W    = 4;
  localparam int STAT_W    = 2;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [PRIO_W-1:0]       prio;
  } entry_t;

  // Operation broadcast to every cell in the chain.
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t ent;
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/spq_cell.sv -----
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
`default_nettype none
module spq_cell
  import spq_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire cmd_t   cmd,
  input  wire logic   left_take,
  input  wire logic   left_valid,
  input  wire entry_t left_ent,
  input  wire logic   right_valid,
  input  wire entry_t right_ent,
  output logic        take,
  output logic        valid,
  output entry_t      ent
);

  logic   valid_r, valid_nxt;
  entry_t ent_r, ent_nxt;

  // Sorted chain: once a cell takes, every cell to its right takes too.
  assign take = !valid_r || (ent_r.prio > cmd.ent.prio);

  always_comb begin
    valid_nxt = valid_r;
    ent_nxt   = ent_r;
    if (cmd.push && take) begin
      // A shifted-in slot is occupied only if its left neighbor was.
      valid_nxt = left_take ? left_valid : 1'b1;
      ent_nxt   = left_take ? left_ent : cmd.ent;
    end else if (cmd.pop) begin
      valid_nxt = right_valid;
      ent_nxt   = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign valid = valid_r;
  assign ent   = ent_r;

endmodule
`default_nettype wire

// ----- rtl/sorted_priority_queue.sv -----
// Sorted priority queue: a chain of compare-and-shift cells, top level.
// Usage:
//   in_*  : one item per accepted handshake (in_valid high, in_stall low).
//           in_kind 0 pushes in_item_value/in_item_priority, 1 pops the front.
//   out_* : one result per item; out_value/out_priority carry the popped
//           entry, out_status reports ok, full (push refused) or empty
//           (pop refused), out_fill_count the entries held afterwards.
// The result is registered at the edge that accepts the item. Throughput is
// one item per cycle unless out_stall holds a result; every cell compares
// and shifts in parallel, so the whole insert or remove is done in that cycle.
// A push lands before the first entry with a larger priority number, so
// equal priorities leave in arrival order.
// When the receiver holds out_stall with a result waiting, in_stall rises
// and the result holds until taken; the next item is accepted in the cycle
// the result leaves.
// Synchronous reset empties the queue and drops any pending result.
// out_fill_count reports the count modulo 16.
`default_nettype none
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_kind,
  input  wire logic signed [VAL_W-1:0]  in_item_value,
  input  wire logic [PRIO_W-1:0]        in_item_priority,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [VAL_W-1:0]       out_value,
  output logic [PRIO_W-1:0]             out_priority,
  output logic [STAT_W-1:0]             out_status,
  output logic [FILL_W-1:0]             out_fill_count
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic             accept, full, empty, push_ok, pop_ok;
  logic [CNT_W-1:0] count_r, count_nxt;
  cmd_t             cmd;

  logic   [DEPTH-1:0] take;
  logic   [DEPTH-1:0] valid;
  entry_t             ent [DEPTH];

  logic                      out_valid_r;
  logic signed [VAL_W-1:0]   value_r;
  logic [PRIO_W-1:0]         prio_r;
  logic [STAT_W-1:0]         status_r;
  logic [FILL_W-1:0]         fill_r;
  logic [CNT_W+FILL_W-1:0]   fill_ext;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign push_ok  = accept && (in_kind == KIND_PUSH) && !full;
  assign pop_ok   = accept && (in_kind == KIND_POP) && !empty;

  assign cmd.push      = push_ok;
  assign cmd.pop       = pop_ok;
  assign cmd.ent.value = in_item_value;
  assign cmd.ent.prio  = in_item_priority;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic   l_take, l_valid, r_valid;
      entry_t l_ent, r_ent;
      if (i == 0) begin : g_head
        assign l_take  = 1'b0;
        assign l_valid = 1'b0;
        assign l_ent   = cmd.ent;
      end else begin : g_mid
        assign l_take  = take[i-1];
        assign l_valid = valid[i-1];
        assign l_ent   = ent[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
        assign r_valid = 1'b0;
        assign r_ent   = ent[i];
      end else begin : g_body
        assign r_valid = valid[i+1];
        assign r_ent   = ent[i+1];
      end
      spq_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .left_take   (l_take),
        .left_valid  (l_valid),
        .left_ent    (l_ent),
        .right_valid (r_valid),
        .right_ent   (r_ent),
        .take        (take[i]),
        .valid       (valid[i]),
        .ent         (ent[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (push_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign fill_ext = {{FILL_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fill_r <= fill_ext[FILL_W-1:0];
      if (pop_ok) begin
        value_r  <= ent[0].value;
        prio_r   <= ent[0].prio;
        status_r <= ST_OK;
      end else begin
        value_r  <= '0;
        prio_r   <= '0;
        if (in_kind == KIND_PUSH) begin
          status_r <= full ? ST_FULL : ST_OK;
        end else begin
          status_r <= ST_EMPTY;
        end
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = value_r;
  assign out_priority   = prio_r;
  assign out_status     = status_r;
  assign out_fill_count = fill_r;

endmodule
`default_nettype wire

// ----- rtl/spq_checker.sv -----
// Port-level checks for the sorted priority queue, bound to the top level.
`default_nettype none
module spq_checker
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic signed [VAL_W-1:0] out_value,
  input wire logic [PRIO_W-1:0]       out_priority,
  input wire logic [STAT_W-1:0]       out_status,
  input wire logic [FILL_W-1:0]       out_fill_count
);

  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(DEPTH);

  // Hold a stalled result.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) &&
      $stable(out_priority) && $stable(out_status) && $stable(out_fill_count))
    else $error("stalled result changed");

  // Back-pressure only while a result waits.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |->
      out_fill_count == FULL_FILL && out_value == '0 && out_priority == '0)
    else $error("refused push with wrong count or payload");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |->
      out_fill_count == '0 && out_value == '0 && out_priority == '0)
    else $error("refused pop with wrong count or payload");

  // An accepted item yields a result on the next cycle.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item produced no result");

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_value      (out_value),
  .out_priority   (out_priority),
  .out_status     (out_status),
  .out_fill_count (out_fill_count)
);
`default_nettype wire

// ----- test/testbench.sv -----
// Testbench for sorted_priority_queue: directed and random items checked against a shadow queue.
module testbench;
  import spq_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int HOLD_CYCLES = 60;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [PRIO_W-1:0]       prio;
    logic [STAT_W-1:0]       status;
    logic [FILL_W-1:0]       fill;
  } outcome_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_kind = KIND_PUSH;
  logic signed [VAL_W-1:0] in_item_value = '0;
  logic [PRIO_W-1:0]       in_item_priority = '0;
  logic                    out_stall = 1'b0;
  logic                    in_stall;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_value;
  logic [PRIO_W-1:0]       out_priority;
  logic [STAT_W-1:0]       out_status;
  logic [FILL_W-1:0]       out_fill_count;

  // Shadow copy of the queue contents, front at index 0.
  entry_t   shadow_entries [DEPTH];
  int       shadow_count = 0;
  outcome_t queued_outcomes [$];

  int errors = 0;
  int cycle_count = 0;
  bit idle_on = 1'b1;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int stall_left = 0;

  sorted_priority_queue #(.DEPTH(DEPTH)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_item_value(in_item_value),
    .in_item_priority(in_item_priority),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_value(out_value),
    .out_priority(out_priority),
    .out_status(out_status),
    .out_fill_count(out_fill_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic outcome_t apply_queue_op(logic kind, logic signed [VAL_W-1:0] value,
                                              logic [PRIO_W-1:0] prio);
    outcome_t res;
    int pos;
    res.value  = '0;
    res.prio   = '0;
    res.status = ST_OK;
    if (kind == KIND_PUSH) begin
      if (shadow_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // Insert before the first strictly larger priority number.
        pos = 0;
        while (pos < shadow_count && shadow_entries[pos].prio <= prio) pos++;
        for (int k = shadow_count; k > pos; k--) shadow_entries[k] = shadow_entries[k-1];
        shadow_entries[pos].value = value;
        shadow_entries[pos].prio  = prio;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.value = shadow_entries[0].value;
      res.prio  = shadow_entries[0].prio;
      for (int k = 0; k + 1 < shadow_count; k++) shadow_entries[k] = shadow_entries[k+1];
      shadow_count--;
    end
    res.fill = shadow_count[FILL_W-1:0];
    return res;
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return {1'b1, {(VAL_W-1){1'b0}}};
      2: return {1'b0, {(VAL_W-1){1'b1}}};
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  // mode 0: full range, 1: few distinct numbers for ties, 2: around the extremes
  function automatic logic [PRIO_W-1:0] rand_prio(int mode);
    if (mode == 1) return $urandom_range(0, 3);
    if (mode == 2) return $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(65534, 65535);
    return $urandom_range(0, 65535);
  endfunction

  task automatic report_mismatch(string field, longint want, longint got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // Predict at the edge that accepts each item.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      queued_outcomes.push_back(apply_queue_op(in_kind, in_item_value, in_item_priority));
  end

  always @(posedge clk) begin : check_result
    outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (queued_outcomes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual value %0d status %0d",
                   $time, out_value, out_status);
      end else begin
        want = queued_outcomes.pop_front();
        if (out_value !== want.value) report_mismatch("value", want.value, out_value);
        if (out_priority !== want.prio) report_mismatch("priority", want.prio, out_priority);
        if (out_status !== want.status) report_mismatch("status", want.status, out_status);
        if (out_fill_count !== want.fill) report_mismatch("fill_count", want.fill, out_fill_count);
      end
    end
  end

  // Receiver: random stalls, plus one long hold when asked.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = rand_gap() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic idle_input(int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Offer one item and return at the edge that accepts it; valid stays high.
  task automatic send_item(logic kind, logic signed [VAL_W-1:0] value, logic [PRIO_W-1:0] prio);
    if (idle_on && $urandom_range(0, 3) == 0) idle_input(rand_gap());
    @(negedge clk);
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_item_value    <= value;
    in_item_priority <= prio;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic test_pop_when_empty();
    send_item(KIND_POP, rand_value(), rand_prio(0));
  endtask

  // Fill to capacity with extreme values and ties, overflow, then drain past empty.
  task automatic test_fill_and_drain();
    send_item(KIND_PUSH, 0, 100);
    send_item(KIND_PUSH, {1'b1, {(VAL_W-1){1'b0}}}, 0);
    send_item(KIND_PUSH, {1'b0, {(VAL_W-1){1'b1}}}, 16'hFFFF);
    send_item(KIND_PUSH, -1, 100);
    send_item(KIND_PUSH, 32'h5555_5555, 100);
    send_item(KIND_PUSH, 32'hAAAA_AAAA, 16'hFFFF);
    send_item(KIND_PUSH, 1, 0);
    send_item(KIND_PUSH, 123, 7);
    send_item(KIND_PUSH, 9, 9);
    send_item(KIND_PUSH, 32'hFFFF_0000, 0);
    repeat (DEPTH + 1) send_item(KIND_POP, rand_value(), rand_prio(0));
  endtask

  task automatic test_output_hold();
    idle_on = 1'b0;
    @(posedge clk);
    hold_request = 1'b1;
    repeat (30)
      send_item($urandom_range(0, 9) < 7 ? KIND_PUSH : KIND_POP, rand_value(), rand_prio(0));
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int push_pct;
    int prio_mode;
    for (int phase = 0; phase < 16; phase++) begin
      push_pct  = $urandom_range(0, 2) == 0 ? 50 : ($urandom_range(0, 1) ? 85 : 20);
      prio_mode = $urandom_range(0, 2);
      // Every fourth phase runs back to back with no idling.
      idle_on = (phase % 4 != 3);
      if (phase == 9) begin
        @(posedge clk);
        hold_request = 1'b1;
      end
      repeat (100)
        send_item($urandom_range(0, 99) < push_pct ? KIND_PUSH : KIND_POP,
                  rand_value(), rand_prio(prio_mode));
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_pop_when_empty();
    test_fill_and_drain();
    test_output_hold();
    test_random_traffic();
    idle_input(1);
    while (queued_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
test/testbench.sv
